### hdl/pidl_pkg.sv
// Shared types and codes for the positional insert/delete list.
package pidl_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         count;
    } t_out;

    typedef struct packed {
        logic [1:0]         op;
        logic [6:0]         pos_m1;
        logic signed [31:0] value;
        logic               tap_load;
        logic               tap_shift;
    } t_cell_ctl;

endpackage

### hdl/positional_insert_delete_list.sv
// Top level of the positional insert/delete list.
// Keeps an ordered list of up to DEPTH signed 32-bit entries in a row of
// cells, one entry per cell. Insert and delete shift the cells behind the
// position in parallel in the cycle the beat is accepted, so an insert, a
// rejected operation or any beat without a returned entry finishes as soon
// as the result register is free, and the next beat may follow at once. A
// read, or a delete that returns the removed entry, snapshots all cells into
// a tap line that then moves toward cell 0 one cell per cycle: such a beat's
// result is ready once the entry at its position (1 to DEPTH) reaches cell 0
// and the result register is free; a new beat is held off until then. One
// result register decouples the output: a result waits there while the next
// beat is accepted. The count field wraps modulo 128 when DEPTH exceeds 127.
module positional_insert_delete_list import pidl_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int UW = $clog2(DEPTH + 1);
    localparam int IW = (UW > 7) ? UW : 7;

    logic [UW-1:0] r_used;
    logic [UW-1:0] n_used;
    logic          r_pend;
    logic [6:0]    r_cnt;
    logic          r_need_tap;
    logic [1:0]    r_status;
    logic [6:0]    r_count;
    logic          r_out_valid;
    t_out          r_out;

    logic          accept;
    logic          finish;
    logic          out_free;
    logic          ok;
    logic [1:0]    status;
    logic [6:0]    pos_m1;
    logic          need_tap;
    logic [IW-1:0] posx;
    logic [IW-1:0] usedx;
    t_cell_ctl     ctl;

    logic signed [31:0] data  [DEPTH];
    logic signed [31:0] tap   [DEPTH];

    assign posx     = IW'(i_in_data.position);
    assign usedx    = IW'(r_used);
    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = r_pend && (r_cnt == 7'd0) && out_free;
    assign o_in_stall = r_pend && !finish;
    assign accept   = i_in_valid && !o_in_stall;

    always_comb begin
        status   = ST_OK;
        n_used   = r_used;
        pos_m1   = i_in_data.position - 7'd1;
        need_tap = 1'b0;
        case (i_in_data.func)
            FUNC_INSERT: begin
                if (r_used == UW'(DEPTH)) begin
                    status = ST_FULL;
                end else if (r_used == '0) begin
                    pos_m1 = 7'd0;
                    n_used = UW'(1);
                end else if (i_in_data.position == 7'd0 || posx > usedx + IW'(1)) begin
                    status = ST_BADPOS;
                end else begin
                    n_used = r_used + UW'(1);
                end
            end
            FUNC_DELETE: begin
                if (r_used == '0) begin
                    status = ST_EMPTY;
                end else if (r_used == UW'(1)) begin
                    pos_m1   = 7'd0;
                    n_used   = '0;
                    need_tap = 1'b1;
                end else if (i_in_data.position == 7'd0 || posx > usedx) begin
                    status = ST_BADPOS;
                end else begin
                    n_used   = r_used - UW'(1);
                    need_tap = 1'b1;
                end
            end
            FUNC_READ: begin
                if (r_used == '0) begin
                    status = ST_EMPTY;
                end else if (i_in_data.position == 7'd0 || posx > usedx) begin
                    status = ST_BADPOS;
                end else begin
                    need_tap = 1'b1;
                end
            end
            default: status = ST_BADPOS;
        endcase
    end

    assign ok = (status == ST_OK);

    always_comb begin
        ctl.op        = CELL_HOLD;
        ctl.pos_m1    = pos_m1;
        ctl.value     = i_in_data.value;
        ctl.tap_load  = accept;
        ctl.tap_shift = r_pend && (r_cnt != 7'd0);
        if (accept && ok && i_in_data.func == FUNC_INSERT) begin
            ctl.op = CELL_INSERT;
        end else if (accept && ok && i_in_data.func == FUNC_DELETE) begin
            ctl.op = CELL_DELETE;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] left_data;
        logic signed [31:0] right_data;
        logic signed [31:0] right_tap;
        if (g == 0) begin : g_first
            assign left_data = i_in_data.value;
        end else begin : g_mid
            assign left_data = data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_data = data[g];
            assign right_tap  = tap[g];
        end else begin : g_inner
            assign right_data = data[g+1];
            assign right_tap  = tap[g+1];
        end
        pidl_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .i_right_tap  (right_tap),
            .o_data       (data[g]),
            .o_tap        (tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_cnt       <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_pend && r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_pend <= 1'b1;
                r_used <= n_used;
                r_cnt  <= (ok && need_tap) ? pos_m1 : 7'd0;
            end else if (finish) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_need_tap <= ok && need_tap;
            r_status   <= status;
            r_count    <= 7'(n_used);
        end
        if (finish) begin
            r_out.status     <= r_status;
            r_out.read_value <= r_need_tap ? tap[0] : 32'sd0;
            r_out.count      <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hdl/pidl_cell.sv
// One storage cell of the list: holds an entry and a readout tap.
module pidl_cell import pidl_pkg::*; #(
    parameter int IW  = 7,
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_left_data,
    input  logic signed [31:0] i_right_data,
    input  logic signed [31:0] i_right_tap,
    output logic signed [31:0] o_data,
    output logic signed [31:0] o_tap
);

    localparam logic [IW-1:0] IdxV = IW'(IDX);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic signed [31:0] r_tap;
    logic signed [31:0] n_tap;
    logic [IW-1:0]      pos;

    assign pos = IW'(i_ctl.pos_m1);

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (IdxV == pos) begin
                    n_data = i_ctl.value;
                end else if (IdxV > pos) begin
                    n_data = i_left_data;
                end
            end
            CELL_DELETE: begin
                if (IdxV >= pos) begin
                    n_data = i_right_data;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_comb begin
        n_tap = r_tap;
        if (i_ctl.tap_load) begin
            n_tap = r_data;
        end else if (i_ctl.tap_shift) begin
            n_tap = i_right_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule
